// ===== rtl/lhbc_pkg.sv =====
// Shared constants for the LED heartbeat and breathing controller.
`default_nettype none
package lhbc_pkg;

   localparam int ElapsedWidth = 17;
   localparam logic [ElapsedWidth-1:0] ELAPSED_MAX = '1;

   localparam logic [7:0] DUTY_MAX = 8'd255;

   // Configuration register indexes.
   localparam int CsrIndexWidth = 3;
   localparam logic [CsrIndexWidth-1:0] CSR_FADE_STEP       = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_FADE_ENTRY_STEP = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_FADE_INTERVAL   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_ON_TIME         = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_OFF_TIME        = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_AUTOSWITCH_MS   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_DEBOUNCE_MS     = 3'd6;
   localparam logic [CsrIndexWidth-1:0] CSR_BUTTON_IDLE     = 3'd7;
   localparam int CsrDataWidth = 16;

   // Register reset values.
   localparam logic [7:0]  RST_FADE_STEP       = 8'd10;
   localparam logic [7:0]  RST_FADE_ENTRY_STEP = 8'd5;
   localparam logic [15:0] RST_FADE_INTERVAL   = 16'd50;
   localparam logic [15:0] RST_ON_TIME         = 16'd80;
   localparam logic [15:0] RST_OFF_TIME        = 16'd840;
   localparam logic [15:0] RST_AUTOSWITCH_MS   = 16'd20000;
   localparam logic [15:0] RST_DEBOUNCE_MS     = 16'd100;
   localparam logic        RST_BUTTON_IDLE     = 1'b1;

   // Switch event codes.
   typedef logic [1:0] event_type;
   localparam event_type EVT_NONE   = 2'd0;
   localparam event_type EVT_AUTO   = 2'd1;
   localparam event_type EVT_BUTTON = 2'd2;
   localparam event_type EVT_UNUSED = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/led_heartbeat_breathe_controller_unit.sv =====
// The result of an item is registered and shown in the cycle after it is accepted.
// Throughput: one item per cycle; the whole update is a single registered pass.
// A new item is taken in the same cycle as the last result is read, so a
// stalled result also holds off the input.
// Synchronous active-high reset returns the state and the configuration
// registers to their default values and empties the output register.
`default_nettype none
module led_heartbeat_breathe_controller_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire                                   req_button_level,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic                                  rsp_mode,
   output logic                                  rsp_pwm_active,
   output logic [7:0]                            rsp_duty,
   output logic                                  rsp_led_lit,
   output lhbc_pkg::event_type                   rsp_switch_event,
   input  wire                                   csr_we,
   input  wire  [lhbc_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire  [lhbc_pkg::CsrDataWidth-1:0]     csr_data
);
   import lhbc_pkg::*;

   // Configuration registers.
   logic [7:0]  fade_step_ff, fade_entry_step_ff;
   logic [15:0] fade_interval_ff, on_time_ff, off_time_ff;
   logic [15:0] autoswitch_ms_ff, debounce_ms_ff;
   logic        button_idle_ff;

   // Controller state.
   logic                    breathing_ff, breathing_in;
   logic [7:0]              fade_level_ff, fade_level_in;
   logic signed [8:0]       fade_delta_ff, fade_delta_in;
   logic [ElapsedWidth-1:0] fade_elapsed_ff, fade_elapsed_in;
   logic [1:0]              beat_phase_ff, beat_phase_in;
   logic [15:0]             beat_wait_ff, beat_wait_in;
   logic [ElapsedWidth-1:0] beat_elapsed_ff, beat_elapsed_in;
   logic [ElapsedWidth-1:0] switch_elapsed_ff, switch_elapsed_in;
   logic                    pending_ff, pending_in;
   logic [ElapsedWidth-1:0] debounce_elapsed_ff, debounce_elapsed_in;
   logic                    stable_ff, stable_in;
   logic                    pwm_on_ff, pwm_on_in;
   logic                    lit_ff, lit_in;

   // Result register.
   logic       rsp_valid_ff;
   logic       mode_ff;
   logic       pwm_active_ff;
   logic [7:0] duty_ff;
   logic       led_lit_ff;
   event_type  event_ff, event_in;

   logic              accept;
   logic signed [9:0] fade_sum;
   logic              do_switch;

   function automatic logic [ElapsedWidth-1:0] sat_inc(input logic [ElapsedWidth-1:0] v);
      sat_inc = (v == ELAPSED_MAX) ? ELAPSED_MAX : v + 1'b1;
   endfunction

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign fade_sum = $signed({2'b00, fade_level_ff}) + $signed({fade_delta_ff[8], fade_delta_ff});

   always_comb begin
      fade_elapsed_in     = sat_inc(fade_elapsed_ff);
      beat_elapsed_in     = sat_inc(beat_elapsed_ff);
      switch_elapsed_in   = sat_inc(switch_elapsed_ff);
      debounce_elapsed_in = sat_inc(debounce_elapsed_ff);
      breathing_in        = breathing_ff;
      fade_level_in       = fade_level_ff;
      fade_delta_in       = fade_delta_ff;
      beat_phase_in       = beat_phase_ff;
      beat_wait_in        = beat_wait_ff;
      pending_in          = pending_ff;
      stable_in           = stable_ff;
      pwm_on_in           = pwm_on_ff;
      lit_in              = lit_ff;
      event_in            = EVT_NONE;
      do_switch           = 1'b0;

      if (breathing_ff) begin
         if (fade_elapsed_in > {1'b0, fade_interval_ff}) begin
            if (fade_sum <= 10'sd0) begin
               fade_level_in = 8'd0;
               fade_delta_in = $signed({1'b0, fade_step_ff});
            end else if (fade_sum >= $signed({2'b00, DUTY_MAX})) begin
               fade_level_in = DUTY_MAX;
               fade_delta_in = 9'sd0 - $signed({1'b0, fade_step_ff});
            end else begin
               fade_level_in = fade_sum[7:0];
            end
            pwm_on_in       = 1'b1;
            fade_elapsed_in = '0;
         end
      end else begin
         if (beat_elapsed_in > {1'b0, beat_wait_ff}) begin
            lit_in    = !beat_phase_ff[0];
            pwm_on_in = 1'b0;
            if (beat_phase_ff == 2'd3) begin
               beat_wait_in  = off_time_ff;
               beat_phase_in = 2'd0;
            end else begin
               beat_wait_in  = on_time_ff;
               beat_phase_in = beat_phase_ff + 2'd1;
            end
            beat_elapsed_in = '0;
         end
      end

      // A bounce back leaves the pending flag set, so the next differing
      // sample is judged against the original start time.
      if (switch_elapsed_in > {1'b0, autoswitch_ms_ff}) begin
         do_switch = 1'b1;
         event_in  = EVT_AUTO;
      end else if (req_button_level != stable_ff) begin
         if (!pending_ff) begin
            pending_in          = 1'b1;
            debounce_elapsed_in = '0;
         end else if (debounce_elapsed_in > {1'b0, debounce_ms_ff}) begin
            pending_in = 1'b0;
            if (stable_ff != button_idle_ff) begin
               do_switch = 1'b1;
               event_in  = EVT_BUTTON;
            end
            stable_in = req_button_level;
         end
      end

      if (do_switch) begin
         pwm_on_in    = 1'b0;
         lit_in       = 1'b0;
         breathing_in = !breathing_ff;
         if (breathing_ff) begin
            beat_elapsed_in = '0;
            beat_phase_in   = 2'd0;
            beat_wait_in    = off_time_ff;
         end else begin
            fade_elapsed_in = ELAPSED_MAX;
            fade_delta_in   = $signed({1'b0, fade_entry_step_ff});
            fade_level_in   = 8'd0;
         end
         switch_elapsed_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_step_ff       <= RST_FADE_STEP;
         fade_entry_step_ff <= RST_FADE_ENTRY_STEP;
         fade_interval_ff   <= RST_FADE_INTERVAL;
         on_time_ff         <= RST_ON_TIME;
         off_time_ff        <= RST_OFF_TIME;
         autoswitch_ms_ff   <= RST_AUTOSWITCH_MS;
         debounce_ms_ff     <= RST_DEBOUNCE_MS;
         button_idle_ff     <= RST_BUTTON_IDLE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FADE_STEP:       fade_step_ff       <= csr_data[7:0];
            CSR_FADE_ENTRY_STEP: fade_entry_step_ff <= csr_data[7:0];
            CSR_FADE_INTERVAL:   fade_interval_ff   <= csr_data;
            CSR_ON_TIME:         on_time_ff         <= csr_data;
            CSR_OFF_TIME:        off_time_ff        <= csr_data;
            CSR_AUTOSWITCH_MS:   autoswitch_ms_ff   <= csr_data;
            CSR_DEBOUNCE_MS:     debounce_ms_ff     <= csr_data;
            CSR_BUTTON_IDLE:     button_idle_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         breathing_ff        <= 1'b0;
         fade_level_ff       <= 8'd0;
         fade_delta_ff       <= $signed({1'b0, RST_FADE_STEP});
         fade_elapsed_ff     <= '0;
         beat_phase_ff       <= 2'd0;
         beat_wait_ff        <= 16'd0;
         beat_elapsed_ff     <= ELAPSED_MAX;
         switch_elapsed_ff   <= '0;
         pending_ff          <= 1'b0;
         debounce_elapsed_ff <= '0;
         stable_ff           <= RST_BUTTON_IDLE;
         pwm_on_ff           <= 1'b0;
         lit_ff              <= 1'b0;
      end else if (accept) begin
         breathing_ff        <= breathing_in;
         fade_level_ff       <= fade_level_in;
         fade_delta_ff       <= fade_delta_in;
         fade_elapsed_ff     <= fade_elapsed_in;
         beat_phase_ff       <= beat_phase_in;
         beat_wait_ff        <= beat_wait_in;
         beat_elapsed_ff     <= beat_elapsed_in;
         switch_elapsed_ff   <= switch_elapsed_in;
         pending_ff          <= pending_in;
         debounce_elapsed_ff <= debounce_elapsed_in;
         stable_ff           <= stable_in;
         pwm_on_ff           <= pwm_on_in;
         lit_ff              <= lit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff       <= breathing_in;
         pwm_active_ff <= pwm_on_in;
         duty_ff       <= pwm_on_in ? fade_level_in : 8'd0;
         led_lit_ff    <= pwm_on_in ? 1'b0 : lit_in;
         event_ff      <= event_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mode         = mode_ff;
   assign rsp_pwm_active   = pwm_active_ff;
   assign rsp_duty         = duty_ff;
   assign rsp_led_lit      = led_lit_ff;
   assign rsp_switch_event = event_ff;

endmodule
`default_nettype wire

// ===== rtl/lhbc_checker.sv =====
// Port-level checks for the LED heartbeat and breathing controller, with its bind.
`default_nettype none
module lhbc_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_ready,
   input wire                                rsp_valid,
   input wire                                rsp_ready,
   input wire                                rsp_mode,
   input wire                                rsp_pwm_active,
   input wire [7:0]                          rsp_duty,
   input wire                                rsp_led_lit,
   input wire lhbc_pkg::event_type           rsp_switch_event
);
   import lhbc_pkg::*;

   // A stalled result must keep its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty) && $stable(rsp_mode))
      else $error("result changed while stalled");

   // The output register always frees a slot when it is empty or being drained.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input refused although the output register is free");

   // The LED is driven either by PWM or digitally, never both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_pwm_active && rsp_led_lit) && (rsp_pwm_active || rsp_duty == 8'd0))
      else $error("PWM and digital drive overlap");

   // A mode switch turns the LED off.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_switch_event != EVT_NONE |-> !rsp_pwm_active && !rsp_led_lit)
      else $error("LED still driven on a mode switch");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_switch_event != EVT_UNUSED)
      else $error("undefined switch event code");

endmodule

bind led_heartbeat_breathe_controller_unit lhbc_checker u_lhbc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_mode         (rsp_mode),
   .rsp_pwm_active   (rsp_pwm_active),
   .rsp_duty         (rsp_duty),
   .rsp_led_lit      (rsp_led_lit),
   .rsp_switch_event (rsp_switch_event)
);
`default_nettype wire

// ===== dv/lhbc_scoreboard_pkg.sv =====
// Scoreboard for the LED heartbeat and breathing controller: next-frame predictor and checker.
`timescale 1ns / 1ps
package lhbc_scoreboard_pkg;
   import lhbc_pkg::*;

   typedef struct {
      logic       mode;
      logic       pwm_active;
      logic [7:0] duty;
      logic       led_lit;
      event_type  switch_event;
   } led_frame_type;

   class breathe_beat_scoreboard;
      // Register copies.
      logic [7:0]  step_after, step_entry;
      logic [15:0] fade_period, on_ms, off_ms, auto_ms, bounce_ms;
      logic        idle_level;

      // Controller state.
      logic                    in_breathing;
      logic [7:0]              fade_lvl;
      logic signed [8:0]       fade_dir;
      logic [ElapsedWidth-1:0] fade_age, beat_age, mode_age, bounce_age;
      logic [1:0]              beat_idx;
      logic [15:0]             beat_hold;
      logic                    bounce_pending, settled_level, pwm_drive, lit_on;

      led_frame_type due_frames[$];
      int            mismatches;

      function new();
         step_after    = RST_FADE_STEP;
         step_entry    = RST_FADE_ENTRY_STEP;
         fade_period   = RST_FADE_INTERVAL;
         on_ms         = RST_ON_TIME;
         off_ms        = RST_OFF_TIME;
         auto_ms       = RST_AUTOSWITCH_MS;
         bounce_ms     = RST_DEBOUNCE_MS;
         idle_level    = RST_BUTTON_IDLE;
         in_breathing  = 1'b0;
         fade_lvl      = '0;
         fade_dir      = $signed({1'b0, RST_FADE_STEP});
         fade_age      = '0;
         beat_idx      = '0;
         beat_hold     = '0;
         beat_age      = ELAPSED_MAX;
         mode_age      = '0;
         bounce_pending = 1'b0;
         bounce_age    = '0;
         settled_level = RST_BUTTON_IDLE;
         pwm_drive     = 1'b0;
         lit_on        = 1'b0;
         mismatches    = 0;
      endfunction

      function void write_reg(logic [CsrIndexWidth-1:0] index, logic [CsrDataWidth-1:0] data);
         case (index)
            CSR_FADE_STEP:       step_after  = data[7:0];
            CSR_FADE_ENTRY_STEP: step_entry  = data[7:0];
            CSR_FADE_INTERVAL:   fade_period = data;
            CSR_ON_TIME:         on_ms       = data;
            CSR_OFF_TIME:        off_ms      = data;
            CSR_AUTOSWITCH_MS:   auto_ms     = data;
            CSR_DEBOUNCE_MS:     bounce_ms   = data;
            CSR_BUTTON_IDLE:     idle_level  = data[0];
            default: ;
         endcase
      endfunction

      function logic [ElapsedWidth-1:0] bump(logic [ElapsedWidth-1:0] age);
         return (age == ELAPSED_MAX) ? age : age + 1'b1;
      endfunction

      function void toggle_mode();
         pwm_drive    = 1'b0;
         lit_on       = 1'b0;
         in_breathing = !in_breathing;
         if (!in_breathing) begin
            beat_age  = '0;
            beat_idx  = '0;
            beat_hold = off_ms;
         end else begin
            // Saturated so that the first duty step lands on the very next tick.
            fade_age = ELAPSED_MAX;
            fade_dir = $signed({1'b0, step_entry});
            fade_lvl = '0;
         end
         mode_age = '0;
      endfunction

      function void note_tick(logic level);
         led_frame_type frame;
         event_type     evt;
         int            sum;
         evt        = EVT_NONE;
         fade_age   = bump(fade_age);
         beat_age   = bump(beat_age);
         mode_age   = bump(mode_age);
         bounce_age = bump(bounce_age);

         if (in_breathing) begin
            if (fade_age > fade_period) begin
               sum = int'(fade_lvl) + int'(fade_dir);
               if (sum <= 0) begin
                  sum      = 0;
                  fade_dir = $signed({1'b0, step_after});
               end else if (sum >= int'(DUTY_MAX)) begin
                  sum      = int'(DUTY_MAX);
                  fade_dir = -$signed({1'b0, step_after});
               end
               fade_lvl  = sum[7:0];
               pwm_drive = 1'b1;
               fade_age  = '0;
            end
         end else if (beat_age > beat_hold) begin
            lit_on    = !beat_idx[0];
            pwm_drive = 1'b0;
            if (beat_idx == 2'd3) begin
               beat_hold = off_ms;
               beat_idx  = '0;
            end else begin
               beat_hold = on_ms;
               beat_idx  = beat_idx + 1'b1;
            end
            beat_age = '0;
         end

         if (mode_age > auto_ms) begin
            toggle_mode();
            evt = EVT_AUTO;
         end else if (level != settled_level) begin
            // A bounce back does not clear the pending flag, so the next change
            // is timed from the first one.
            if (!bounce_pending) begin
               bounce_pending = 1'b1;
               bounce_age     = '0;
            end else if (bounce_age > bounce_ms) begin
               bounce_pending = 1'b0;
               if (settled_level != idle_level) begin
                  toggle_mode();
                  evt = EVT_BUTTON;
               end
               settled_level = level;
            end
         end

         frame.mode         = in_breathing;
         frame.pwm_active   = pwm_drive;
         frame.duty         = pwm_drive ? fade_lvl : 8'd0;
         frame.led_lit      = pwm_drive ? 1'b0 : lit_on;
         frame.switch_event = evt;
         due_frames.push_back(frame);
      endfunction

      function void check_frame(logic mode, logic pwm_active, logic [7:0] duty,
                                logic led_lit, event_type switch_event);
         led_frame_type want;
         if (due_frames.size() == 0) begin
            $error("result item arrived with nothing expected");
            mismatches++;
            return;
         end
         want = due_frames.pop_front();
         if (mode !== want.mode) begin
            $error("mode: expected %0d, got %0d", want.mode, mode);
            mismatches++;
         end
         if (pwm_active !== want.pwm_active) begin
            $error("pwm_active: expected %0d, got %0d", want.pwm_active, pwm_active);
            mismatches++;
         end
         if (duty !== want.duty) begin
            $error("duty: expected %0d, got %0d", want.duty, duty);
            mismatches++;
         end
         if (led_lit !== want.led_lit) begin
            $error("led_lit: expected %0d, got %0d", want.led_lit, led_lit);
            mismatches++;
         end
         if (switch_event !== want.switch_event) begin
            $error("switch_event: expected %0d, got %0d", want.switch_event, switch_event);
            mismatches++;
         end
      endfunction

      function int frames_due();
         return due_frames.size();
      endfunction
   endclass

endpackage

// ===== dv/testbench.sv =====
// Randomised handshake testbench for the LED heartbeat and breathing controller.
`timescale 1ns / 1ps
module testbench;
   import lhbc_pkg::*;
   import lhbc_scoreboard_pkg::*;

   localparam int NumRegs       = 8;
   localparam int RandomItems   = 1330;
   localparam int WatchdogLimit = 2000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid, req_ready, req_button_level;
   logic                     rsp_valid, rsp_ready;
   logic                     rsp_mode, rsp_pwm_active, rsp_led_lit;
   logic [7:0]               rsp_duty;
   event_type                rsp_switch_event;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_data;

   breathe_beat_scoreboard sb;
   logic [CsrDataWidth-1:0] reg_plan [NumRegs];
   bit  steady;
   int  random_sent;
   int  quiet_cycles;

   led_heartbeat_breathe_controller_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_button_level (req_button_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mode         (rsp_mode),
      .rsp_pwm_active   (rsp_pwm_active),
      .rsp_duty         (rsp_duty),
      .rsp_led_lit      (rsp_led_lit),
      .rsp_switch_event (rsp_switch_event),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short pauses with the odd long one.
   function automatic int stall_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic int sender_gap();
      if (steady || $urandom_range(0, 2) != 0) return 0;
      return stall_length();
   endfunction

   function automatic logic [CsrDataWidth-1:0] pick_step();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return 16'd255;
      if (r == 2) return 16'd1;
      return CsrDataWidth'($urandom_range(1, 255));
   endfunction

   task automatic send_tick(input logic level);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_button_level <= level;
      do @(posedge clock); while (!req_ready);
      sb.note_tick(level);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.frames_due() != 0);
   endtask

   task automatic program_regs();
      for (int i = 0; i < NumRegs; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CsrIndexWidth'(i);
         csr_data  <= reg_plan[i];
         @(posedge clock);
         sb.write_reg(CsrIndexWidth'(i), reg_plan[i]);
      end
      csr_we <= 1'b0;
   endtask

   task automatic run_directed();
      // Default settings: the beat age starts saturated, so the LED lights at once.
      repeat (4) send_tick(1'b1);
      wait_drained();

      // Fast auto switching, a full-scale entry step and a zero step afterwards.
      reg_plan[CSR_FADE_STEP]       = '0;
      reg_plan[CSR_FADE_ENTRY_STEP] = 16'd255;
      reg_plan[CSR_FADE_INTERVAL]   = '0;
      reg_plan[CSR_ON_TIME]         = '0;
      reg_plan[CSR_OFF_TIME]        = 16'd1;
      reg_plan[CSR_AUTOSWITCH_MS]   = 16'd2;
      reg_plan[CSR_DEBOUNCE_MS]     = '0;
      reg_plan[CSR_BUTTON_IDLE]     = 16'd1;
      program_regs();
      repeat (8) send_tick(1'b1);
      wait_drained();

      // Press accepted, bounce back while pending, then a release that switches.
      reg_plan[CSR_FADE_STEP]       = 16'd255;
      reg_plan[CSR_FADE_ENTRY_STEP] = 16'd1;
      reg_plan[CSR_OFF_TIME]        = '0;
      reg_plan[CSR_AUTOSWITCH_MS]   = 16'hFFFF;
      reg_plan[CSR_DEBOUNCE_MS]     = 16'd1;
      program_regs();
      repeat (3) send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      repeat (3) send_tick(1'b1);
   endtask

   task automatic run_random_phase();
      int   kind, len, sent, hold, bounces, cap;
      bit   noisy, pressed;
      logic idle, level;
      wait_drained();
      kind   = $urandom_range(0, 9);
      steady = ($urandom_range(0, 3) == 0);
      noisy  = ($urandom_range(0, 4) == 0);
      len    = $urandom_range(60, 180);
      reg_plan[CSR_BUTTON_IDLE] = CsrDataWidth'($urandom_range(0, 1));
      if (kind == 0) begin
         reg_plan[CSR_FADE_STEP]       = 16'd255;
         reg_plan[CSR_FADE_ENTRY_STEP] = 16'd255;
         reg_plan[CSR_FADE_INTERVAL]   = 16'hFFFF;
         reg_plan[CSR_ON_TIME]         = 16'hFFFF;
         reg_plan[CSR_OFF_TIME]        = 16'hFFFF;
         reg_plan[CSR_AUTOSWITCH_MS]   = 16'hFFFF;
         reg_plan[CSR_DEBOUNCE_MS]     = 16'hFFFF;
         len = 40;
      end else if (kind == 1) begin
         // A zero auto-switch time toggles the mode on every item.
         reg_plan[CSR_FADE_STEP]       = '0;
         reg_plan[CSR_FADE_ENTRY_STEP] = '0;
         reg_plan[CSR_FADE_INTERVAL]   = '0;
         reg_plan[CSR_ON_TIME]         = '0;
         reg_plan[CSR_OFF_TIME]        = '0;
         reg_plan[CSR_AUTOSWITCH_MS]   = '0;
         reg_plan[CSR_DEBOUNCE_MS]     = '0;
         len = 40;
      end else begin
         reg_plan[CSR_FADE_STEP]       = pick_step();
         reg_plan[CSR_FADE_ENTRY_STEP] = pick_step();
         reg_plan[CSR_FADE_INTERVAL]   = CsrDataWidth'($urandom_range(0, 6));
         reg_plan[CSR_ON_TIME]         = CsrDataWidth'($urandom_range(0, 10));
         reg_plan[CSR_OFF_TIME]        = CsrDataWidth'($urandom_range(0, 25));
         reg_plan[CSR_AUTOSWITCH_MS]   = ($urandom_range(0, 7) == 0) ?
                                         16'hFFFF : CsrDataWidth'($urandom_range(15, 300));
         reg_plan[CSR_DEBOUNCE_MS]     = CsrDataWidth'($urandom_range(0, 12));
      end
      if (len > RandomItems - random_sent) len = RandomItems - random_sent;
      program_regs();

      idle    = reg_plan[CSR_BUTTON_IDLE][0];
      cap     = (reg_plan[CSR_DEBOUNCE_MS] > 40) ? 40 : int'(reg_plan[CSR_DEBOUNCE_MS]);
      pressed = 1'b0;
      sent    = 0;
      while (sent < len) begin
         if (noisy) begin
            send_tick(1'($urandom_range(0, 1)));
            sent++;
         end else begin
            pressed = !pressed;
            level   = pressed ? !idle : idle;
            // Contact bounce at the start of a press or release.
            bounces = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
            for (int k = 0; k < bounces; k++) send_tick((k % 2) ? !level : level);
            hold = $urandom_range(1, cap + 8);
            repeat (hold) send_tick(level);
            sent += bounces + hold;
            if ($urandom_range(0, 9) == 0) wait_drained();
         end
      end
      random_sent += sent;
   endtask

   // Result side: random back-pressure.
   initial begin
      int stall;
      stall = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) stall = stall_length();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_frame(rsp_mode, rsp_pwm_active, rsp_duty, rsp_led_lit, rsp_switch_event);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("led_heartbeat_breathe_controller_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      sb               = new();
      steady           = 1'b0;
      random_sent      = 0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_button_level <= 1'b0;
      csr_we           <= 1'b0;
      csr_index        <= CSR_FADE_STEP;
      csr_data         <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      while (random_sent < RandomItems) run_random_phase();
      wait_drained();
      repeat (4) @(posedge clock);

      if (sb.mismatches == 0 && sb.frames_due() == 0) begin
         $display("led_heartbeat_breathe_controller_unit verification clean");
      end else begin
         $display("led_heartbeat_breathe_controller_unit verification failed");
      end
      $finish;
   end

endmodule
